FILE: rtl/core/pcs_pkg.sv
// Package for the prime count and sum block: widths, limits and word types.
// Depends on nothing; every module of the block refers to it by scoped names.
package pcs_pkg;

  localparam int VALUE_BITS = 16;
  localparam int MAX_ITEMS  = 65536;

  // A value that can be prime is positive, so its magnitude fits below the sign bit.
  localparam int MAG_BITS = VALUE_BITS - 1;
  // The divisor square runs one bit wider than the magnitude before the loop exits.
  localparam int SQ_BITS  = MAG_BITS + 1;
  localparam int CNT_BITS = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;

  localparam int COUNT_BITS      = 17;
  localparam int SUM_BITS        = 31;
  localparam int COUNT_FIELD_MAX = 131071;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX =
    COUNT_BITS'((MAX_ITEMS < COUNT_FIELD_MAX) ? MAX_ITEMS : COUNT_FIELD_MAX);
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } in_t;

  typedef struct packed {
    logic                  is_prime;
    logic [COUNT_BITS-1:0] prime_count;
    logic [SUM_BITS-1:0]   prime_sum;
    logic                  last_out;
  } out_t;

  // Request to and answer from the shared remainder unit.
  typedef struct packed {
    logic                start;
    logic [MAG_BITS-1:0] dividend;
    logic [MAG_BITS-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

  // Verdict of the trial division sequencer for one word.
  typedef struct packed {
    logic                is_prime;
    logic [MAG_BITS-1:0] mag;
    logic                last;
  } trial_res_t;

endpackage

FILE: rtl/core/prime_count_and_sum_top.sv
// Top level of the prime count and sum block: running totals and output register.
// Depends on pcs_pkg and instantiates pcs_trial.
//
// Usage. Words arrive on the input channel (in_valid, in_ready, in_data) as a signed
// value and a last flag. Each word yields exactly one word on the output channel
// (out_valid, out_ready, out_data): the prime flag, the count and the sum of primes
// seen so far in the current set, this word included, and a copy of the last flag.
// After a word marked last both totals return to zero. The count saturates at its
// limit and the sum at the largest 31-bit value.
//
// Timing. One word is worked on at a time; in_ready is low while it is in progress.
// Negative values, values below four and even values are settled at classification.
// Otherwise odd divisors from three upwards are tried until the divisor squared
// exceeds the value or a divisor leaves no remainder, each in the shared bit-serial
// remainder unit.
//
// Reset (rst, synchronous) clears the totals, the sequencer and the output valid.
// A stalled receiver holds the result in the output register; the next word is
// still accepted and worked on, and waits at the sequencer until the register frees.
module prime_count_and_sum_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pcs_pkg::out_t out_data
);

  logic                           res_valid;
  logic                           res_ready;
  pcs_pkg::trial_res_t            res;
  logic [pcs_pkg::COUNT_BITS-1:0] count;
  logic [pcs_pkg::SUM_BITS-1:0]   sum;
  logic [pcs_pkg::COUNT_BITS-1:0] count_next;
  logic [pcs_pkg::SUM_BITS-1:0]   sum_next;
  logic [pcs_pkg::SUM_BITS:0]     sum_wide;

  pcs_trial u_trial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register takes a verdict when it is empty or being emptied.
  assign res_ready = !out_valid || out_ready;

  // Only a prime moves the totals; both saturate rather than wrap.
  always_comb begin
    sum_wide = {1'b0, sum} +
               {{(pcs_pkg::SUM_BITS + 1 - pcs_pkg::MAG_BITS){1'b0}}, res.mag};
    count_next = count;
    sum_next   = sum;
    if (res.is_prime) begin
      if (count < pcs_pkg::COUNT_MAX) begin
        count_next = count + 1'b1;
      end
      if (sum_wide > {1'b0, pcs_pkg::SUM_MAX}) begin
        sum_next = pcs_pkg::SUM_MAX;
      end else begin
        sum_next = sum_wide[pcs_pkg::SUM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
      sum       <= '0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        if (res.last) begin
          count <= '0;
          sum   <= '0;
        end else begin
          count <= count_next;
          sum   <= sum_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data.is_prime    <= res.is_prime;
      out_data.prime_count <= count_next;
      out_data.prime_sum   <= sum_next;
      out_data.last_out    <= res.last;
    end
  end

endmodule

FILE: rtl/core/pcs_rem.sv
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on pcs_pkg for widths and the request and answer structs.
module pcs_rem (
  input  logic             clk,
  input  logic             rst,
  input  pcs_pkg::rem_req_t req,
  output pcs_pkg::rem_rsp_t rsp
);

  logic                         active;
  logic                         done;
  logic [pcs_pkg::CNT_BITS-1:0] cnt;
  logic [pcs_pkg::MAG_BITS-1:0] dvd;
  logic [pcs_pkg::MAG_BITS-1:0] dsr;
  logic [pcs_pkg::MAG_BITS-1:0] rem;
  logic [pcs_pkg::MAG_BITS:0]   rem_sh;
  logic [pcs_pkg::MAG_BITS:0]   rem_sub;
  logic [pcs_pkg::MAG_BITS-1:0] rem_next;

  always_comb begin
    rem_sh  = {rem, dvd[pcs_pkg::MAG_BITS-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    if (rem_sh >= {1'b0, dsr}) begin
      rem_next = rem_sub[pcs_pkg::MAG_BITS-1:0];
    end else begin
      rem_next = rem_sh[pcs_pkg::MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (cnt == '0);
      if (req.start) begin
        active <= 1'b1;
      end else if (active && (cnt == '0)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      cnt <= pcs_pkg::CNT_BITS'(pcs_pkg::MAG_BITS - 1);
    end else if (active) begin
      dvd <= {dvd[pcs_pkg::MAG_BITS-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.zero = (rem == '0);

endmodule

FILE: rtl/core/pcs_trial.sv
// Trial division sequencer: classifies a word and steps odd divisors through pcs_rem.
// Depends on pcs_pkg and instantiates pcs_rem.
module pcs_trial (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcs_pkg::in_t        in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output pcs_pkg::trial_res_t res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLASS = 5'b00010,
    S_LOOP  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic                        neg;
  logic                        last;
  logic                        prime;
  logic [pcs_pkg::MAG_BITS-1:0] n;
  logic [pcs_pkg::MAG_BITS-1:0] d;
  logic [pcs_pkg::SQ_BITS-1:0]  sq;
  logic [pcs_pkg::SQ_BITS-1:0]  sq_step;
  logic                        sq_over;
  pcs_pkg::rem_req_t           req;
  pcs_pkg::rem_rsp_t           rsp;

  pcs_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // (d + 2)^2 = d^2 + 4d + 4, so the square is kept without a multiplier.
  // A divisor that is tried never passes the square root of the largest magnitude, so its
  // top two bits are always clear.
  assign sq_step = {d[pcs_pkg::MAG_BITS-3:0], 2'b00} + pcs_pkg::SQ_BITS'(4);
  assign sq_over = (sq > {1'b0, n});

  assign req.start    = (state == S_LOOP) && !sq_over;
  assign req.dividend = n;
  assign req.divisor  = d;

  assign in_ready     = (state == S_IDLE);
  assign res_valid    = (state == S_DONE);
  assign res.is_prime = prime;
  assign res.mag      = n;
  assign res.last     = last;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (neg || (n[pcs_pkg::MAG_BITS-1:2] == '0) || !n[0]) begin
          state_next = S_DONE;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        state_next = sq_over ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (rsp.done) begin
          state_next = rsp.zero ? S_DONE : S_LOOP;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n    <= in_data.value[pcs_pkg::MAG_BITS-1:0];
        neg  <= in_data.value[pcs_pkg::VALUE_BITS-1];
        last <= in_data.last;
      end
      S_CLASS: begin
        // Two and three are prime; below two, negative or even above that is not.
        prime <= !neg && (n[pcs_pkg::MAG_BITS-1:2] == '0) && n[1];
        d     <= pcs_pkg::MAG_BITS'(3);
        sq    <= pcs_pkg::SQ_BITS'(9);
      end
      S_LOOP: begin
        if (sq_over) begin
          prime <= 1'b1;
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          if (rsp.zero) begin
            prime <= 1'b0;
          end
          d  <= d + pcs_pkg::MAG_BITS'(2);
          sq <= sq + sq_step;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: test/tb_prime_count_and_sum_top.sv
// Self-checking testbench for prime_count_and_sum_top: primality flag and running totals.
// Depends on pcs_pkg and the RTL of the block. It predicts every result word in a small
// scoreboard class and drives both handshake channels from plain tasks and processes.
module tb_prime_count_and_sum_top;

  // Each side waits a random idle gap, from none up to IDLE_MAX, before offering or taking a word.
  localparam int IDLE_MAX     = 13;
  // One long hold-off of the receiver, long enough for the block to fill and stall.
  localparam int HOLD_CYCLES  = 600;
  // The watchdog allows a wide margin on top of the slowest word's trial division
  // plus the long hold-off.
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int RANDOM_WORDS = 250;
  localparam int MAX_REPORTS  = 40;

  // The scoreboard keeps its own copy of the running count and sum, predicts the
  // result word for every accepted input word and checks results in order.
  class prime_tally_board;
    logic [pcs_pkg::COUNT_BITS-1:0] run_count;
    logic [pcs_pkg::SUM_BITS-1:0]   run_sum;
    pcs_pkg::out_t                  expected_totals[$];
    int                             errors;
    int                             noted;
    int                             checked;
    int                             primes_seen;
    int                             sets_closed;
    int                             saturated_hits;

    function new();
      run_count      = '0;
      run_sum        = '0;
      errors         = 0;
      noted          = 0;
      checked        = 0;
      primes_seen    = 0;
      sets_closed    = 0;
      saturated_hits = 0;
    endfunction

    // Plain trial division over odd divisors up to the square root.
    function bit value_is_prime(int v);
      int d;
      if (v < 2) return 1'b0;
      if (v < 4) return 1'b1;
      if (v % 2 == 0) return 1'b0;
      for (d = 3; d * d <= v; d += 2) begin
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function pcs_pkg::out_t predict_totals(pcs_pkg::in_t w);
      pcs_pkg::out_t r;
      int            v;
      longint        s;
      v = int'($signed(w.value));
      r.is_prime = value_is_prime(v);
      if (r.is_prime) begin
        primes_seen++;
        if (run_count < pcs_pkg::COUNT_MAX) begin
          run_count++;
        end else begin
          saturated_hits++;
        end
        s = longint'(run_sum) + longint'(v);
        run_sum = (s > longint'(pcs_pkg::SUM_MAX)) ? pcs_pkg::SUM_MAX :
                  s[pcs_pkg::SUM_BITS-1:0];
      end
      r.prime_count = run_count;
      r.prime_sum   = run_sum;
      r.last_out    = w.last;
      // The result still shows the totals of the closing word; the set starts afresh.
      if (w.last) begin
        run_count = '0;
        run_sum   = '0;
        sets_closed++;
      end
      return r;
    endfunction

    function void note_word(pcs_pkg::in_t w);
      expected_totals.push_back(predict_totals(w));
      noted++;
    endfunction

    function void flag_error(string field, logic [pcs_pkg::SUM_BITS:0] want,
                             logic [pcs_pkg::SUM_BITS:0] got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $error("%s: expected %0d, got %0d", field, want, got);
      end else if (errors == MAX_REPORTS + 1) begin
        $display("Further mismatches are counted but not listed.");
      end
    endfunction

    function void check_word(pcs_pkg::out_t got);
      pcs_pkg::out_t want;
      if (expected_totals.size() == 0) begin
        flag_error("unexpected result word, prime_count", '0, got.prime_count);
        return;
      end
      want = expected_totals.pop_front();
      checked++;
      if (got.is_prime !== want.is_prime)
        flag_error("is_prime", want.is_prime, got.is_prime);
      if (got.prime_count !== want.prime_count)
        flag_error("prime_count", want.prime_count, got.prime_count);
      if (got.prime_sum !== want.prime_sum)
        flag_error("prime_sum", want.prime_sum, got.prime_sum);
      if (got.last_out !== want.last_out)
        flag_error("last_out", want.last_out, got.last_out);
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  pcs_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  pcs_pkg::out_t out_data;

  prime_tally_board board = new();

  // Idling limits for each side; the stimulus switches them off for some stretches.
  int tx_idle_max  = IDLE_MAX;
  int rx_idle_max  = IDLE_MAX;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;
  int holds_done   = 0;
  int stall_cycles = 0;

  prime_count_and_sum_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pcs_pkg::in_t make_word(int v, bit last);
    pcs_pkg::in_t w;
    w.value = v[pcs_pkg::VALUE_BITS-1:0];
    w.last  = last;
    return w;
  endfunction

  // Random words lean towards the interesting regions: any 16-bit pattern, negatives
  // included, the values around two, small numbers and primes, and large values whose
  // trial division runs long. Roughly one word in twelve closes a set.
  function automatic pcs_pkg::in_t random_word();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      v = int'($signed(16'($urandom())));
    end else if (pick < 25) begin
      v = $urandom_range(0, 3);
    end else if (pick < 50) begin
      v = $urandom_range(4, 255);
    end else if (pick < 65) begin
      do v = $urandom_range(2, 500); while (!board.value_is_prime(v));
    end else if (pick < 80) begin
      v = $urandom_range(16384, 32767);
    end else begin
      do v = $urandom_range(1000, 32767); while (!board.value_is_prime(v));
    end
    return make_word(v, $urandom_range(0, 11) == 0);
  endfunction

  // Offers one word after an idle gap and returns at the falling edge after it has
  // been accepted. A gap of zero leaves in_valid high from the previous word.
  task automatic send_word(input pcs_pkg::in_t w, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
    @(negedge clk);
  endtask

  // The receiver takes result words for the whole run. Any word that turns up
  // without an expectation waiting is reported by the scoreboard.
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, rx_idle_max);
      if (hold_request) begin
        gap += HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_word(out_data);
      @(negedge clk);
    end
  end

  // The watchdog ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("prime_count_and_sum_top: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    // Directed words: extremes of the value field, the values below two, two and three,
    // even numbers, squares of primes (the divisor squared equals the value), the
    // largest prime, and set closures on a prime, on a non-prime and back to back.
    int directed_vals[23] = '{-32768, -1, 0, 1, 2, 3, 4, 5, 9, 25, 169, 32761, 32749,
                              32767, 32766, 16384, 97, -3, 7, 11, 8, 17, 32749};
    bit directed_last[23] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0,
                              0, 0, 0, 0, 0, 1, 1, 1, 0, 1};
    int i;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < 23; i++) begin
      send_word(make_word(directed_vals[i], directed_last[i]), $urandom_range(0, tx_idle_max));
    end

    // Back-pressure: the receiver stops for a long stretch while words keep coming with
    // no gaps, so the output register and the sequencer both fill and in_ready drops.
    tx_idle_max  = 0;
    hold_request = 1'b1;
    for (i = 0; i < 12; i++) begin
      send_word(make_word($urandom_range(0, 200), $urandom_range(0, 7) == 0), 0);
    end
    send_word(make_word(32749, 1'b0), 0);

    // Random words, with idling switched off on both sides now and then.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 30 == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          tx_idle_max = 0;
          rx_idle_max = 0;
        end else begin
          tx_idle_max = IDLE_MAX;
          rx_idle_max = IDLE_MAX;
        end
      end
      send_word(random_word(), $urandom_range(0, tx_idle_max));
    end
    send_word(make_word(3, 1'b1), $urandom_range(0, tx_idle_max));

    // A non-prime, a closing prime and a fresh set to show the totals cleared.
    tx_idle_max = 0;
    rx_idle_max = 0;
    send_word(make_word(9, 1'b0), 0);
    send_word(make_word(5, 1'b1), 0);
    send_word(make_word(2, 1'b1), 0);
    in_valid <= 1'b0;

    // Let every expected word arrive, then give the block time to show any stray one.
    while (board.expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d words in %0d sets, %0d primes, %0d receiver hold-offs.",
             board.noted, board.sets_closed, board.primes_seen, holds_done);
    $display("%0d result words checked; %0d primes arrived with the count saturated.",
             board.checked, board.saturated_hits);
    if (board.errors == 0) begin
      $display("prime_count_and_sum_top: match");
    end else begin
      $display("prime_count_and_sum_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pcs_pkg.sv
rtl/core/pcs_rem.sv
rtl/core/pcs_trial.sv
rtl/core/prime_count_and_sum_top.sv
test/tb_prime_count_and_sum_top.sv
